### hdl/tlfq_pkg.sv
// shared types, constants and helpers of the three-level feedback queue scheduler
package tlfq_pkg;

    localparam int LEVEL_ONE_DEPTH   = 128;
    localparam int LEVEL_TWO_DEPTH   = 128;
    localparam int LEVEL_THREE_DEPTH = 128;
    localparam int BURST_BITS        = 10;

    localparam int ID_W    = 10;
    localparam int FIELD_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_LEVELS = 3;

    localparam int MAX_DEPTH =
        (LEVEL_ONE_DEPTH > LEVEL_TWO_DEPTH) ?
            ((LEVEL_ONE_DEPTH > LEVEL_THREE_DEPTH) ? LEVEL_ONE_DEPTH : LEVEL_THREE_DEPTH) :
            ((LEVEL_TWO_DEPTH > LEVEL_THREE_DEPTH) ? LEVEL_TWO_DEPTH : LEVEL_THREE_DEPTH);
    localparam int HEAD_W = $clog2(MAX_DEPTH);
    localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int RUN_W  = (BURST_BITS > FIELD_W) ? BURST_BITS : FIELD_W;

    localparam logic [FIELD_W-1:0] QUANTUM_ONE_RESET = FIELD_W'(5);
    localparam logic [FIELD_W-1:0] QUANTUM_TWO_RESET = FIELD_W'(10);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_ONE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TWO = CFG_IDX_W'(1);

    // serve phase: level index, or done until the next advance
    localparam logic [1:0] PH_ONE   = 2'd0;
    localparam logic [1:0] PH_TWO   = 2'd1;
    localparam logic [1:0] PH_THREE = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    typedef enum logic [1:0] {
        ACT_ARRIVE   = 2'd0,
        ACT_DISPATCH = 2'd1,
        ACT_ADVANCE  = 2'd2,
        ACT_IDLE     = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        RES_IDLE        = 3'd0,
        RES_ADMITTED    = 3'd1,
        RES_ARRIVE_DROP = 3'd2,
        RES_MOVED       = 3'd3,
        RES_FINISHED    = 3'd4,
        RES_ADVANCED    = 3'd5,
        RES_MOVE_DROP   = 3'd6
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [BURST_BITS-1:0] burst;
        logic [BURST_BITS-1:0] rem;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic int lvl_depth(input int lv);
        int d;
        d = LEVEL_THREE_DEPTH;
        if (lv == 0) begin
            d = LEVEL_ONE_DEPTH;
        end else if (lv == 1) begin
            d = LEVEL_TWO_DEPTH;
        end
        return d;
    endfunction

endpackage

### hdl/tlfq_ram.sv
// generic single-write, single-read ram with registered read data
module tlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/tlfq_ctrl.sv
// controller: takes an input word, then runs the execute step once the result slot is free
module tlfq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tlfq_pkg::t_status i_status,
    output tlfq_pkg::t_cmd    o_cmd
);
    import tlfq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the previous result has left the output register
                o_cmd.commit = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.commit == i_status.out_free)
        else $error("execute step not taken after capture");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && !i_status.out_free) |=> !o_in_ready)
        else $error("input taken while a word is still in execution");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_in_ready)
        else $error("controller not idle after commit");

endmodule

### hdl/tlfq_dp.sv
// datapath: level queues in ram, heads and counts, phase and time, result register
module tlfq_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tlfq_pkg::t_cmd                       i_cmd,
    output tlfq_pkg::t_status                    o_status,
    input  logic [1:0]                           i_action,
    input  logic [tlfq_pkg::ID_W-1:0]            i_process_id,
    input  logic [tlfq_pkg::FIELD_W-1:0]         i_burst_length,
    input  logic                                 i_route_bit,
    input  logic                                 i_cfg_valid,
    input  logic [tlfq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tlfq_pkg::FIELD_W-1:0]         i_cfg_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [2:0]                           o_result_code,
    output logic [tlfq_pkg::ID_W-1:0]            o_job_id,
    output logic [1:0]                           o_served_level,
    output logic [tlfq_pkg::FIELD_W-1:0]         o_run_amount,
    output logic [tlfq_pkg::FIELD_W-1:0]         o_remaining_after,
    output logic [1:0]                           o_destination_level,
    output logic [tlfq_pkg::FIELD_W-1:0]         o_total_burst
);
    import tlfq_pkg::*;

    // captured input word
    t_action               r_action;
    logic [ID_W-1:0]       r_pid;
    logic [FIELD_W-1:0]    r_burst;
    logic                  r_route;

    logic [FIELD_W-1:0]    r_q1;
    logic [FIELD_W-1:0]    r_q2;

    logic [HEAD_W-1:0]     r_head  [NUM_LEVELS];
    logic [CNT_W-1:0]      r_count [NUM_LEVELS];
    logic [HEAD_W-1:0]     n_head  [NUM_LEVELS];
    logic [CNT_W-1:0]      n_count [NUM_LEVELS];
    logic [2:0]            r_time;
    logic [2:0]            n_time;
    logic [1:0]            r_phase;
    logic [1:0]            n_phase;

    logic                  r_out_valid;
    t_result               r_code;
    logic [ID_W-1:0]       r_jid;
    logic [1:0]            r_served;
    logic [FIELD_W-1:0]    r_run;
    logic [FIELD_W-1:0]    r_rem;
    logic [1:0]            r_dest;
    logic [FIELD_W-1:0]    r_total;

    t_result               n_code;
    logic [ID_W-1:0]       n_jid;
    logic [1:0]            n_served;
    logic [FIELD_W-1:0]    n_run;
    logic [FIELD_W-1:0]    n_rem;
    logic [1:0]            n_dest;
    logic [FIELD_W-1:0]    n_total;

    logic [HEAD_W-1:0]     tail     [NUM_LEVELS];
    logic [ENTRY_W-1:0]    ram_rd   [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] full;
    logic [NUM_LEVELS-1:0] nonempty;
    logic [NUM_LEVELS-1:0] elig;
    logic [1:0]            sel;
    t_entry                head_entry;
    logic                  pop_en;
    logic                  push_en;
    logic [1:0]            push_lvl;
    t_entry                push_entry;
    logic                  push_full;
    logic [RUN_W-1:0]      burst_ext;
    logic [RUN_W-1:0]      rem_ext;
    logic [RUN_W-1:0]      quantum;
    logic [RUN_W-1:0]      run_amt;
    logic [RUN_W-1:0]      rem_left;
    logic [RUN_W-1:0]      total_ext;

    assign o_status.out_free = !r_out_valid || i_out_ready;

    // per-level tail address and fill flags
    always_comb begin
        logic [SUM_W-1:0] sum;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            sum = SUM_W'(r_head[l]) + SUM_W'(r_count[l]);
            if (sum >= SUM_W'(lvl_depth(l))) begin
                sum = sum - SUM_W'(lvl_depth(l));
            end
            tail[l]     = sum[HEAD_W-1:0];
            full[l]     = r_count[l] >= CNT_W'(lvl_depth(l));
            nonempty[l] = r_count[l] != '0;
        end
    end

    assign elig[0] = nonempty[0] && !r_time[0];
    assign elig[1] = nonempty[1] && !nonempty[0] && (r_time == 3'd0 || r_time == 3'd3);
    assign elig[2] = nonempty[2] && !nonempty[0] && !nonempty[1];

    // phase search from the current phase, ends at done when nothing qualifies
    always_comb begin
        if (r_phase == PH_ONE && elig[0]) begin
            sel = PH_ONE;
        end else if ((r_phase == PH_ONE || r_phase == PH_TWO) && elig[1]) begin
            sel = PH_TWO;
        end else if (r_phase != PH_DONE && elig[2]) begin
            sel = PH_THREE;
        end else begin
            sel = PH_DONE;
        end
    end

    always_comb begin
        case (sel)
            PH_ONE:   head_entry = t_entry'(ram_rd[0]);
            PH_TWO:   head_entry = t_entry'(ram_rd[1]);
            PH_THREE: head_entry = t_entry'(ram_rd[2]);
            default:  head_entry = '0;
        endcase
    end

    assign rem_ext   = RUN_W'(head_entry.rem);
    assign burst_ext = RUN_W'(r_burst);

    always_comb begin
        case (sel)
            PH_ONE:  quantum = RUN_W'(r_q1);
            PH_TWO:  quantum = RUN_W'(r_q2);
            default: quantum = rem_ext;
        endcase
    end

    assign run_amt   = (rem_ext < quantum) ? rem_ext : quantum;
    assign rem_left  = rem_ext - run_amt;
    assign total_ext = RUN_W'(head_entry.burst);

    always_comb begin
        case (push_lvl)
            PH_ONE:   push_full = full[0];
            PH_TWO:   push_full = full[1];
            PH_THREE: push_full = full[2];
            default:  push_full = 1'b1;
        endcase
    end

    // execute step for the captured word
    always_comb begin
        n_time     = r_time;
        n_phase    = r_phase;
        pop_en     = 1'b0;
        push_en    = 1'b0;
        push_lvl   = PH_ONE;
        push_entry = head_entry;
        n_code     = RES_IDLE;
        n_jid      = '0;
        n_served   = '0;
        n_run      = '0;
        n_rem      = '0;
        n_dest     = '0;
        n_total    = '0;
        unique case (r_action)
            ACT_ARRIVE: begin
                push_en          = 1'b1;
                push_entry.id    = r_pid;
                push_entry.burst = burst_ext[BURST_BITS-1:0];
                push_entry.rem   = burst_ext[BURST_BITS-1:0];
                n_jid            = r_pid;
                n_code           = push_full ? RES_ARRIVE_DROP : RES_ADMITTED;
            end
            ACT_DISPATCH: begin
                n_phase = sel;
                if (sel != PH_DONE) begin
                    pop_en         = 1'b1;
                    push_entry.rem = rem_left[BURST_BITS-1:0];
                    n_jid          = head_entry.id;
                    n_served       = sel + 2'd1;
                    n_run          = run_amt[FIELD_W-1:0];
                    n_rem          = rem_left[FIELD_W-1:0];
                    if (rem_left == '0) begin
                        n_code  = RES_FINISHED;
                        n_total = total_ext[FIELD_W-1:0];
                    end else begin
                        // level one leftovers go down, levels two and three by the route bit
                        if (sel == PH_ONE) begin
                            push_lvl = PH_TWO;
                        end else begin
                            push_lvl = r_route ? PH_THREE : PH_ONE;
                        end
                        push_en = 1'b1;
                        n_dest  = push_lvl + 2'd1;
                        n_code  = push_full ? RES_MOVE_DROP : RES_MOVED;
                    end
                end
            end
            ACT_ADVANCE: begin
                n_time  = (r_time == 3'd5) ? 3'd0 : r_time + 3'd1;
                n_phase = PH_ONE;
                n_code  = RES_ADVANCED;
            end
            ACT_IDLE: begin
                n_code = RES_IDLE;
            end
            default: begin
                n_code = RES_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            n_head[l]  = r_head[l];
            n_count[l] = r_count[l];
            if (pop_en && sel == 2'(l)) begin
                n_head[l]  = (CNT_W'(r_head[l]) + CNT_W'(1) == CNT_W'(lvl_depth(l))) ?
                             '0 : r_head[l] + HEAD_W'(1);
                n_count[l] = r_count[l] - CNT_W'(1);
            end
            if (push_en && push_lvl == 2'(l) && !full[l]) begin
                n_count[l] = r_count[l] + CNT_W'(1);
            end
        end
    end

    generate
        for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_level
            localparam int AW = $clog2(lvl_depth(l));
            logic we;
            assign we = i_cmd.commit && push_en && push_lvl == 2'(l) && !full[l];
            tlfq_ram #(
                .WIDTH (ENTRY_W),
                .DEPTH (lvl_depth(l))
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (we),
                .i_waddr (tail[l][AW-1:0]),
                .i_wdata (push_entry),
                .i_re    (i_cmd.capture),
                .i_raddr (r_head[l][AW-1:0]),
                .o_rdata (ram_rd[l])
            );
        end
    endgenerate

    // captured word, result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= t_action'(i_action);
            r_pid    <= i_process_id;
            r_burst  <= i_burst_length;
            r_route  <= i_route_bit;
        end
        if (i_cmd.commit) begin
            r_code   <= n_code;
            r_jid    <= n_jid;
            r_served <= n_served;
            r_run    <= n_run;
            r_rem    <= n_rem;
            r_dest   <= n_dest;
            r_total  <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1        <= QUANTUM_ONE_RESET;
            r_q2        <= QUANTUM_TWO_RESET;
            r_time      <= '0;
            r_phase     <= PH_ONE;
            r_out_valid <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_QUANTUM_ONE: r_q1 <= i_cfg_data;
                    CFG_QUANTUM_TWO: r_q2 <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit) begin
                r_time  <= n_time;
                r_phase <= n_phase;
                for (int l = 0; l < NUM_LEVELS; l++) begin
                    r_head[l]  <= n_head[l];
                    r_count[l] <= n_count[l];
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_result_code       = r_code;
    assign o_job_id            = r_jid;
    assign o_served_level      = r_served;
    assign o_run_amount        = r_run;
    assign o_remaining_after   = r_rem;
    assign o_destination_level = r_dest;
    assign o_total_burst       = r_total;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> o_status.out_free)
        else $error("result overwritten before it was taken");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> o_out_valid)
        else $error("no result after execute step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[0] <= CNT_W'(LEVEL_ONE_DEPTH) && r_count[1] <= CNT_W'(LEVEL_TWO_DEPTH) &&
        r_count[2] <= CNT_W'(LEVEL_THREE_DEPTH))
        else $error("level count beyond its depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_action == ACT_ADVANCE) |=> r_phase == PH_ONE)
        else $error("phase not back at level one after advance");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && pop_en) |-> (r_time[0] == 1'b0 || sel != PH_ONE))
        else $error("level one served on odd time");

endmodule

### hdl/three_level_feedback_queue_scheduler_unit.sv
// top level of the three-level feedback queue scheduler
//
//  channel  direction  handshake                  payload
//  in       to block   i_in_valid / o_in_ready    action, process_id, burst_length, route_bit
//  out      from block o_out_valid / i_out_ready  result_code .. total_burst
//  cfg      to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// each word is accepted in the idle state, which reads the head of every level ram;
// the execute state then updates heads, counts, phase and time and writes at most
// one level tail. a result still waiting in the output register holds the execute state.
// after reset all levels are empty; ram contents need no clearing pass.
// configuration writes are always ready and take effect the next cycle.
module three_level_feedback_queue_scheduler_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_action,
    input  logic [tlfq_pkg::ID_W-1:0]            i_process_id,
    input  logic [tlfq_pkg::FIELD_W-1:0]         i_burst_length,
    input  logic                                 i_route_bit,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tlfq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tlfq_pkg::FIELD_W-1:0]         i_cfg_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [2:0]                           o_result_code,
    output logic [tlfq_pkg::ID_W-1:0]            o_job_id,
    output logic [1:0]                           o_served_level,
    output logic [tlfq_pkg::FIELD_W-1:0]         o_run_amount,
    output logic [tlfq_pkg::FIELD_W-1:0]         o_remaining_after,
    output logic [1:0]                           o_destination_level,
    output logic [tlfq_pkg::FIELD_W-1:0]         o_total_burst
);
    import tlfq_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    tlfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tlfq_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_action            (i_action),
        .i_process_id        (i_process_id),
        .i_burst_length      (i_burst_length),
        .i_route_bit         (i_route_bit),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_result_code       (o_result_code),
        .o_job_id            (o_job_id),
        .o_served_level      (o_served_level),
        .o_run_amount        (o_run_amount),
        .o_remaining_after   (o_remaining_after),
        .o_destination_level (o_destination_level),
        .o_total_burst       (o_total_burst)
    );

endmodule
